>>> hw/rtl/mavgcal_pkg.sv
package mavgcal_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_SAVE   = 2'd2
    } t_op;

    typedef struct packed {
        logic push;
        logic ld2;
        logic ld3;
    } t_stage_en;

    localparam int SAMPLE_W = 16;
    localparam int CORR_W   = 17;
    localparam int AXES     = 3;

endpackage

>>> hw/rtl/mavgcal_if.sv
interface mavgcal_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;

    modport source (output valid, operation, sample_x, sample_y, sample_z, input ready);
    modport sink (input valid, operation, sample_x, sample_y, sample_z, output ready);
endinterface

interface mavgcal_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] avg_x;
    logic signed [15:0] avg_y;
    logic signed [15:0] avg_z;
    logic signed [16:0] corr_x;
    logic signed [16:0] corr_y;
    logic signed [16:0] corr_z;

    modport source (output valid, avg_x, avg_y, avg_z, corr_x, corr_y, corr_z, input ready);
    modport sink (input valid, avg_x, avg_y, avg_z, corr_x, corr_y, corr_z, output ready);
endinterface

>>> hw/rtl/mavgcal_axis_avg.sv
module mavgcal_axis_avg #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mavgcal_pkg::t_stage_en              i_en,
    input  logic signed [mavgcal_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [mavgcal_pkg::SAMPLE_W-1:0] o_avg
);
    import mavgcal_pkg::*;

    localparam int LW = $clog2(WINDOW_LEN);
    localparam int SW = SAMPLE_W + LW;
    localparam int SH = SW + LW;
    localparam int RW = SW + 2;
    localparam int PW = SW + RW;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RW-1:0] RECIP = RECIP_L[RW-1:0];

    logic signed [SAMPLE_W-1:0] r_win [WINDOW_LEN];
    logic signed [SW-1:0]       r_sum;
    logic signed [SW-1:0]       n_sum;
    logic [SW-1:0]              mag;
    logic [PW-1:0]              r_prod;
    logic                       r_neg;
    logic [SAMPLE_W-1:0]        quot;
    logic signed [SAMPLE_W-1:0] r_avg;

    assign n_sum = r_sum + SW'(i_sample) - SW'(r_win[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_win[k] <= '0;
            end
            r_sum <= '0;
        end else if (i_en.push) begin
            for (int k = 0; k < WINDOW_LEN - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[WINDOW_LEN-1] <= i_sample;
            r_sum <= n_sum;
        end
    end

    // The quotient is exact for every sum magnitude below 2**SW.
    assign mag = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r_prod <= PW'(mag) * PW'(RECIP);
            r_neg  <= r_sum[SW-1];
        end
    end

    assign quot = r_prod[SH +: SAMPLE_W];

    always_ff @(posedge i_clk) begin
        if (i_en.ld3) begin
            r_avg <= r_neg ? SAMPLE_W'(-quot) : quot;
        end
    end

    assign o_avg = r_avg;

endmodule

>>> hw/rtl/magnetometer_average_calibration.sv
// Conditions a three-axis magnetometer stream. A sample word shifts each axis reading into a
// WINDOW_LEN-deep window and yields one result word with the truncated window averages and the
// averages minus the stored hard-iron offsets. A start word clears the tracked minimum and
// maximum and enters calibration; a save word loads each offset with the midpoint of its
// minimum and maximum and leaves calibration. Start, save and unused operation codes give no
// result. The block is a four-stage pipeline (window sum, reciprocal multiply, sign restore,
// calibration and output register) and accepts one word every cycle; it only stalls when the
// output register is held and all stages behind it are full.
module magnetometer_average_calibration #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mavgcal_in_if.sink          i_in,
    mavgcal_out_if.source       o_out
);
    import mavgcal_pkg::*;

    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic accept;
    logic op_known;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    t_op  r_op1;
    t_op  r_op2;
    t_op  r_op3;

    t_stage_en                  stage_en;
    logic signed [SAMPLE_W-1:0] samples [AXES];
    logic signed [SAMPLE_W-1:0] avg [AXES];

    logic                       r_cal;
    logic                       n_cal;
    logic signed [SAMPLE_W-1:0] r_min [AXES];
    logic signed [SAMPLE_W-1:0] r_max [AXES];
    logic signed [SAMPLE_W-1:0] r_off [AXES];
    logic signed [SAMPLE_W-1:0] n_min [AXES];
    logic signed [SAMPLE_W-1:0] n_max [AXES];
    logic signed [SAMPLE_W-1:0] n_off [AXES];
    logic signed [SAMPLE_W-1:0] r_avg_out [AXES];
    logic signed [CORR_W-1:0]   r_corr_out [AXES];
    logic signed [CORR_W-1:0]   mid_sum [AXES];
    logic signed [CORR_W-1:0]   mid_adj [AXES];

    assign en4 = !r_v4 || o_out.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready = en1;
    assign accept     = i_in.valid && en1;
    assign op_known   = (i_in.operation == OP_SAMPLE) || (i_in.operation == OP_START)
                     || (i_in.operation == OP_SAVE);

    assign stage_en.push = accept && (i_in.operation == OP_SAMPLE);
    assign stage_en.ld2  = en2;
    assign stage_en.ld3  = en3;

    assign samples[0] = i_in.sample_x;
    assign samples[1] = i_in.sample_y;
    assign samples[2] = i_in.sample_z;

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        mavgcal_axis_avg #(
            .WINDOW_LEN (WINDOW_LEN)
        ) u_avg (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (stage_en),
            .i_sample (samples[a]),
            .o_avg    (avg[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept && op_known;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3 && (r_op3 == OP_SAMPLE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_op1 <= t_op'(i_in.operation);
        end
        if (en2) begin
            r_op2 <= r_op1;
        end
        if (en3) begin
            r_op3 <= r_op2;
        end
    end

    always_comb begin
        n_cal = r_cal;
        for (int a = 0; a < AXES; a++) begin
            n_min[a]   = r_min[a];
            n_max[a]   = r_max[a];
            n_off[a]   = r_off[a];
            mid_sum[a] = CORR_W'(r_max[a]) + CORR_W'(r_min[a]);
            mid_adj[a] = mid_sum[a] + CORR_W'(mid_sum[a][CORR_W-1]);
        end
        if (r_v3) begin
            unique case (r_op3)
                OP_SAMPLE: begin
                    if (r_cal) begin
                        for (int a = 0; a < AXES; a++) begin
                            if (avg[a] < r_min[a]) begin
                                n_min[a] = avg[a];
                            end
                            if (avg[a] > r_max[a]) begin
                                n_max[a] = avg[a];
                            end
                        end
                    end
                end
                OP_START: begin
                    n_cal = 1'b1;
                    for (int a = 0; a < AXES; a++) begin
                        n_min[a] = '0;
                        n_max[a] = '0;
                    end
                end
                OP_SAVE: begin
                    n_cal = 1'b0;
                    for (int a = 0; a < AXES; a++) begin
                        n_off[a] = mid_adj[a][SAMPLE_W:1];
                    end
                end
                default: begin
                    n_cal = r_cal;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_min[a] <= '0;
                r_max[a] <= '0;
                r_off[a] <= '0;
            end
        end else if (en4) begin
            r_cal <= n_cal;
            for (int a = 0; a < AXES; a++) begin
                r_min[a] <= n_min[a];
                r_max[a] <= n_max[a];
                r_off[a] <= n_off[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            for (int a = 0; a < AXES; a++) begin
                r_avg_out[a]  <= avg[a];
                r_corr_out[a] <= CORR_W'(avg[a]) - CORR_W'(r_off[a]);
            end
        end
    end

    assign o_out.valid  = r_v4;
    assign o_out.avg_x  = r_avg_out[0];
    assign o_out.avg_y  = r_avg_out[1];
    assign o_out.avg_z  = r_avg_out[2];
    assign o_out.corr_x = r_corr_out[0];
    assign o_out.corr_y = r_corr_out[1];
    assign o_out.corr_z = r_corr_out[2];

endmodule

>>> test/magnetometer_average_calibration_test.sv
`timescale 1ns / 100ps

module magnetometer_average_calibration_test;
    import mavgcal_pkg::*;

    localparam int DEPTH = 10;
    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic signed [SAMPLE_W-1:0] avg [AXES];
        logic signed [CORR_W-1:0]   corr [AXES];
    } t_reading;

    class window_calibrator;
        logic signed [SAMPLE_W-1:0] history [AXES][DEPTH];
        logic signed [SAMPLE_W-1:0] lowest [AXES];
        logic signed [SAMPLE_W-1:0] highest [AXES];
        logic signed [SAMPLE_W-1:0] offset [AXES];
        bit calibrating;
        t_reading due_readings [$];
        string axis_tag [AXES] = '{"x", "y", "z"};
        int mismatches;
        int readings_checked;

        function new();
            foreach (history[a, k]) history[a][k] = '0;
            foreach (offset[a]) begin
                lowest[a] = '0;
                highest[a] = '0;
                offset[a] = '0;
            end
            calibrating = 1'b0;
            mismatches = 0;
            readings_checked = 0;
        endfunction

        function int pending();
            return due_readings.size();
        endfunction

        function void take_word(logic [1:0] code, logic signed [SAMPLE_W-1:0] sx,
                                logic signed [SAMPLE_W-1:0] sy,
                                logic signed [SAMPLE_W-1:0] sz);
            logic signed [SAMPLE_W-1:0] fresh [AXES];
            logic signed [SAMPLE_W-1:0] mean;
            t_reading due;
            int total;
            fresh[0] = sx;
            fresh[1] = sy;
            fresh[2] = sz;
            case (code)
                OP_START: begin
                    calibrating = 1'b1;
                    foreach (lowest[a]) begin
                        lowest[a] = '0;
                        highest[a] = '0;
                    end
                end
                OP_SAVE: begin
                    foreach (offset[a])
                        offset[a] = SAMPLE_W'((int'(highest[a]) + int'(lowest[a])) / 2);
                    calibrating = 1'b0;
                end
                OP_SAMPLE: begin
                    for (int a = 0; a < AXES; a++) begin
                        total = 0;
                        for (int k = 0; k < DEPTH - 1; k++) history[a][k] = history[a][k + 1];
                        history[a][DEPTH - 1] = fresh[a];
                        for (int k = 0; k < DEPTH; k++) total += int'(history[a][k]);
                        mean = SAMPLE_W'(total / DEPTH);
                        if (calibrating) begin
                            if (mean < lowest[a]) lowest[a] = mean;
                            if (mean > highest[a]) highest[a] = mean;
                        end
                        due.avg[a] = mean;
                        due.corr[a] = CORR_W'(int'(mean) - int'(offset[a]));
                    end
                    due_readings.push_back(due);
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, logic signed [31:0] want_v, logic signed [31:0] got_v);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("Mismatch in %s of reading %0d: expected %0d, got %0d",
                         what, readings_checked, want_v, got_v);
        endfunction

        function void check_reading(t_reading got);
            t_reading want;
            if (due_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Result word with nothing pending: avg %0d %0d %0d",
                             got.avg[0], got.avg[1], got.avg[2]);
                return;
            end
            want = due_readings.pop_front();
            readings_checked++;
            for (int a = 0; a < AXES; a++) begin
                if (got.avg[a] !== want.avg[a])
                    flag($sformatf("avg_%s", axis_tag[a]), want.avg[a], got.avg[a]);
                if (got.corr[a] !== want.corr[a])
                    flag($sformatf("corr_%s", axis_tag[a]), want.corr[a], got.corr[a]);
            end
        endfunction

        function void close_out();
            if (due_readings.size() != 0) begin
                mismatches += due_readings.size();
                $display("%0d expected results never arrived", due_readings.size());
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mavgcal_in_if  in_bus ();
    mavgcal_out_if out_bus ();

    magnetometer_average_calibration #(
        .WINDOW_LEN(DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    window_calibrator model = new();

    int cycles = 0;
    int burst_left = 0;
    bit quiet_stretch = 1'b0;
    int drift [AXES] = '{0, 0, 0};
    int items_sent = 0;
    int n_samples = 0;
    int n_starts = 0;
    int n_saves = 0;
    int n_unused = 0;
    int ready_left = 0;
    int ready_mode = 0;
    int ready_period = 2;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("magnetometer_average_calibration_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin : watch
        t_reading got;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                got.avg[0] = out_bus.avg_x;
                got.avg[1] = out_bus.avg_y;
                got.avg[2] = out_bus.avg_z;
                got.corr[0] = out_bus.corr_x;
                got.corr[1] = out_bus.corr_y;
                got.corr[2] = out_bus.corr_z;
                model.check_reading(got);
            end
            if (in_bus.valid && in_bus.ready)
                model.take_word(in_bus.operation, in_bus.sample_x, in_bus.sample_y,
                                in_bus.sample_z);
        end
    end

    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(16, 160);
            ready_period = $urandom_range(2, 7);
        end
        ready_left = ready_left - 1;
        case (ready_mode)
            0: out_bus.ready <= 1'b1;
            1: out_bus.ready <= ($urandom_range(0, 1) == 1);
            2: out_bus.ready <= (ready_left % ready_period == 0);
            default: out_bus.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic hold_off(int gap);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            in_bus.operation <= 2'($urandom);
            in_bus.sample_x <= 16'($urandom);
            in_bus.sample_y <= 16'($urandom);
            in_bus.sample_z <= 16'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic issue(logic [1:0] code, logic signed [15:0] sx, logic signed [15:0] sy,
                         logic signed [15:0] sz);
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) quiet_stretch = !quiet_stretch;
            hold_off(quiet_stretch ? 0 : $urandom_range(1, 10));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_bus.valid <= 1'b1;
        in_bus.operation <= code;
        in_bus.sample_x <= sx;
        in_bus.sample_y <= sy;
        in_bus.sample_z <= sz;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        case (code)
            OP_SAMPLE: n_samples++;
            OP_START: n_starts++;
            OP_SAVE: n_saves++;
            default: n_unused++;
        endcase
        if (code != OP_UNUSED) items_sent++;
    endtask

    function automatic logic signed [15:0] pick_sample(int centre);
        int mode;
        int v;
        mode = $urandom_range(0, 15);
        if (mode == 0) return 16'sh7FFF;
        if (mode == 1) return 16'sh8000;
        if (mode <= 4) return 16'($urandom);
        v = centre + int'($urandom_range(0, 2000)) - 1000;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic send_samples(int count);
        for (int i = 0; i < count; i++) begin
            foreach (drift[a]) drift[a] += int'($urandom_range(0, 600)) - 300;
            issue(OP_SAMPLE, pick_sample(drift[0]), pick_sample(drift[1]),
                  pick_sample(drift[2]));
        end
    endtask

    task automatic run_directed();
        issue(OP_UNUSED, 16'sh7FFF, 16'sh8000, 16'sh5555);
        issue(OP_SAVE, 16'sh0000, 16'sh0000, 16'sh0000);
        for (int i = 0; i < DEPTH; i++)
            issue(OP_SAMPLE, 16'sh8000, 16'sh7FFF, (i % 2 == 0) ? 16'sh7FFF : 16'sh8000);
        issue(OP_START, 16'($urandom), 16'($urandom), 16'($urandom));
        issue(OP_START, 16'($urandom), 16'($urandom), 16'($urandom));
        issue(OP_SAMPLE, 16'sh8000, 16'sh7FFF, 16'shFFFF);
        issue(OP_SAVE, 16'($urandom), 16'($urandom), 16'($urandom));
        for (int i = 0; i < DEPTH; i++)
            issue(OP_SAMPLE, 16'sh7FFF, 16'sh8000, (i % 3 == 0) ? 16'shFFFF : 16'sh0001);
        issue(OP_SAVE, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic run_random();
        int choice;
        while (items_sent < ITEM_TARGET) begin
            choice = $urandom_range(0, 99);
            if (choice < 12) begin
                foreach (drift[a]) drift[a] = int'($urandom_range(0, 60000)) - 30000;
                issue(OP_START, 16'($urandom), 16'($urandom), 16'($urandom));
                send_samples($urandom_range(3, 40));
                if ($urandom_range(0, 5) == 0) begin
                    issue(OP_START, 16'($urandom), 16'($urandom), 16'($urandom));
                    send_samples($urandom_range(2, 15));
                end
                if ($urandom_range(0, 7) != 0)
                    issue(OP_SAVE, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (choice < 16) begin
                case ($urandom_range(0, 2))
                    0: issue(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
                    1: issue(OP_SAVE, 16'($urandom), 16'($urandom), 16'($urandom));
                    default: issue(OP_START, 16'($urandom), 16'($urandom), 16'($urandom));
                endcase
            end else begin
                send_samples($urandom_range(1, 30));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.operation = OP_SAMPLE;
        in_bus.sample_x = '0;
        in_bus.sample_y = '0;
        in_bus.sample_z = '0;
        out_bus.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        in_bus.valid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        model.close_out();
        $display("Sent %0d sample words, %0d calibration starts, %0d saves, %0d unused codes.",
                 n_samples, n_starts, n_saves, n_unused);
        $display("Checked %0d result words in %0d cycles with %0d mismatches.",
                 model.readings_checked, cycles, model.mismatches);
        if (model.mismatches == 0) begin
            $display("magnetometer_average_calibration_test OK");
        end else begin
            $display("magnetometer_average_calibration_test NOT OK");
        end
        $finish;
    end

endmodule
